// ===== hdl/tpr_pkg.sv =====
// tpr_pkg: shared types, codes and constants of the tapered parameter ramp
// holds the state type, request and register codes and the exp2 root table
// no dependencies
package tpr_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIVX,
      ST_POW,
      ST_NORM,
      ST_LOG,
      ST_SCALE,
      ST_DIVB,
      ST_EXPSET,
      ST_EXP,
      ST_EXPFIN,
      ST_PDONE,
      ST_BLEND1,
      ST_BLEND2,
      ST_MULD,
      ST_FINAL,
      ST_OUT
   } state_type;

   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_SET    = 2'd1;
   localparam logic [1:0] REQ_SAMPLE = 2'd2;
   localparam logic [1:0] REQ_SKIP   = 2'd3;

   localparam logic [1:0] CSR_TAPER  = 2'd0;
   localparam logic [1:0] CSR_SKEW   = 2'd1;
   localparam logic [1:0] CSR_OFFSET = 2'd2;

   localparam logic [15:0] TAPER_RESET = 16'd4096;
   localparam logic [16:0] ONE_Q16     = 17'h10000;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

   typedef logic [30:0] root_tbl_type [16];

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = val;
      r = '0;
      b = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (b > v) b = b >> 2;
      end
      for (int k = 0; k < 32; k++) begin
         if (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // 2^(2^-i) in Q1.30 for i = 1..16, by repeated truncated roots
   function automatic root_tbl_type root_table();
      root_tbl_type tbl;
      logic [63:0]  c;
      c = isqrt64(64'd1 << 61);
      for (int i = 0; i < 16; i++) begin
         tbl[i] = c[30:0];
         c = isqrt64(c << 30);
      end
      return tbl;
   endfunction

   localparam root_tbl_type ROOT_TBL = root_table();

endpackage

// ===== hdl/tapered_parameter_ramp.sv =====
// tapered_parameter_ramp: smooths a Q16.16 parameter toward a target along a tapered curve
// depends on tpr_pkg for codes, state type and the exp2 root table
//
// A sample word during a running ramp passes a bit-serial divider that forms the elapsed
// fraction (16 steps) and the inverse-taper exponent (33 steps), and the log2 squaring and
// exp2 product loops, each taking one step a cycle (16 each, twice), plus up to 15
// normalize shifts for the smaller of the two bases; the loops after the first divide are
// skipped when the elapsed fraction is zero. A stalled output holds the word in the output
// state. A sample word outside a ramp goes straight to the output state; start, set and skip
// words finish in the idle state. The input stalls until the current word is finished; a
// finished result waits in the output register while the next word is taken.
module tapered_parameter_ramp (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_new_value,
   input  logic [19:0]        req_ramp_length,
   input  logic [19:0]        req_skip_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_param_value,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_wdata
);

   tpr_pkg::state_type state_ff, state_in;

   logic [15:0]        taper_ff, taper_in;
   logic [16:0]        skew_ff, skew_in;
   logic [19:0]        offset_ff, offset_in;
   logic signed [31:0] start_ff, start_in;
   logic signed [31:0] goal_ff, goal_in;
   logic [19:0]        total_ff, total_in;
   logic [19:0]        left_ff, left_in;
   logic               phase_ff, phase_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [20:0]        rem_ff, rem_in;
   logic [32:0]        quo_ff, quo_in;
   logic [15:0]        x_ff, x_in;
   logic [3:0]         n_ff, n_in;
   logic [30:0]        m_ff, m_in;
   logic [15:0]        frac_ff, frac_in;
   logic [30:0]        v_ff, v_in;
   logic [15:0]        g_ff, g_in;
   logic [16:0]        pow_ff, pow_in;
   logic [16:0]        p1_ff, p1_in;
   logic [33:0]        acc_ff, acc_in;
   logic signed [50:0] prod_ff, prod_in;
   logic signed [31:0] res_ff, res_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;

   logic        req_acc;
   logic        rsp_free;
   logic [15:0] taper_eff;
   logic [16:0] skew_eff;
   logic [20:0] div_den;
   logic [20:0] div_sh;
   logic        div_ge;
   logic [20:0] div_rem;
   logic [16:0] u_val;
   logic [61:0] sq;
   logic [31:0] sq_hi;
   logic [20:0] a_val;
   logic [36:0] at_prod;
   logic [61:0] vc_prod;
   logic [16:0] q_val;
   logic [5:0]  sh_amt;
   logic [16:0] exp_res;
   logic [16:0] w_val;
   logic signed [32:0] d_val;
   logic signed [50:0] adj;
   logic [19:0] left_dec;

   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign taper_eff = (taper_ff == '0) ? 16'd1 : taper_ff;
   assign skew_eff  = (skew_ff > tpr_pkg::ONE_Q16) ? tpr_pkg::ONE_Q16 : skew_ff;
   assign left_dec  = left_ff - 20'd1;

   // shared restoring divider
   assign div_den = (state_ff == tpr_pkg::ST_DIVX) ? {1'b0, total_ff} : {5'b0, taper_eff};
   assign div_sh  = {rem_ff[19:0], quo_ff[32]};
   assign div_ge  = div_sh >= div_den;
   assign div_rem = div_ge ? div_sh - div_den : div_sh;

   assign u_val   = phase_ff ? tpr_pkg::ONE_Q16 - {1'b0, x_ff} : {1'b0, x_ff};
   assign sq      = 62'(m_ff) * 62'(m_ff);
   assign sq_hi   = sq[61:30];
   assign a_val   = {5'(5'd16 - {1'b0, n_ff}), 16'b0} - {5'b0, frac_ff};
   assign at_prod = 37'(a_val) * 37'(taper_eff);
   assign vc_prod = 62'(v_ff) * 62'(tpr_pkg::ROOT_TBL[cnt_ff[3:0]]);
   assign q_val   = quo_ff[32:16];
   assign sh_amt  = 6'd14 + {1'b0, q_val[4:0]} + {5'b0, (quo_ff[15:0] != '0)};
   assign exp_res = (q_val > 17'd16) ? 17'd0 : 17'(v_ff >> sh_amt[4:0]);
   assign w_val   = acc_ff[32:16];
   assign d_val   = 33'(goal_ff) - 33'(start_ff);
   assign adj     = prod_ff + ((prod_ff < 0) ? 51'sd65535 : 51'sd0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpr_pkg::ST_IDLE: begin
            if (req_acc && req_type == tpr_pkg::REQ_SAMPLE) begin
               if (left_ff != '0 && total_ff != '0 && left_ff <= total_ff)
                  state_in = tpr_pkg::ST_DIVX;
               else
                  state_in = tpr_pkg::ST_OUT;
            end
         end
         tpr_pkg::ST_DIVX:   if (cnt_ff == 6'd15) state_in = tpr_pkg::ST_POW;
         tpr_pkg::ST_POW: begin
            if (u_val == '0 || u_val[16]) state_in = tpr_pkg::ST_PDONE;
            else state_in = tpr_pkg::ST_NORM;
         end
         tpr_pkg::ST_NORM:   if (m_ff[30]) state_in = tpr_pkg::ST_LOG;
         tpr_pkg::ST_LOG:    if (cnt_ff == 6'd15) state_in = tpr_pkg::ST_SCALE;
         tpr_pkg::ST_SCALE:  state_in = phase_ff ? tpr_pkg::ST_DIVB : tpr_pkg::ST_EXPSET;
         tpr_pkg::ST_DIVB:   if (cnt_ff == 6'd32) state_in = tpr_pkg::ST_EXPSET;
         tpr_pkg::ST_EXPSET: state_in = tpr_pkg::ST_EXP;
         tpr_pkg::ST_EXP:    if (cnt_ff == 6'd15) state_in = tpr_pkg::ST_EXPFIN;
         tpr_pkg::ST_EXPFIN: state_in = tpr_pkg::ST_PDONE;
         tpr_pkg::ST_PDONE:  state_in = phase_ff ? tpr_pkg::ST_BLEND1 : tpr_pkg::ST_POW;
         tpr_pkg::ST_BLEND1: state_in = tpr_pkg::ST_BLEND2;
         tpr_pkg::ST_BLEND2: state_in = tpr_pkg::ST_MULD;
         tpr_pkg::ST_MULD:   state_in = tpr_pkg::ST_FINAL;
         tpr_pkg::ST_FINAL:  state_in = tpr_pkg::ST_OUT;
         tpr_pkg::ST_OUT:    if (rsp_free) state_in = tpr_pkg::ST_IDLE;
         default:            state_in = tpr_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      taper_in     = taper_ff;
      skew_in      = skew_ff;
      offset_in    = offset_ff;
      start_in     = start_ff;
      goal_in      = goal_ff;
      total_in     = total_ff;
      left_in      = left_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      x_in         = x_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      v_in         = v_ff;
      g_in         = g_ff;
      pow_in       = pow_ff;
      p1_in        = p1_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_we) begin
         unique case (csr_index)
            tpr_pkg::CSR_TAPER:  taper_in  = csr_wdata[15:0];
            tpr_pkg::CSR_SKEW:   skew_in   = csr_wdata[16:0];
            tpr_pkg::CSR_OFFSET: offset_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         tpr_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (req_type)
                  tpr_pkg::REQ_START, tpr_pkg::REQ_SET: begin
                     if (req_type == tpr_pkg::REQ_START && req_ramp_length != '0) begin
                        start_in = goal_ff;
                        goal_in  = req_new_value;
                        total_in = req_ramp_length;
                        left_in  = (req_ramp_length > offset_ff) ?
                                   req_ramp_length - offset_ff : '0;
                     end else begin
                        start_in = req_new_value;
                        goal_in  = req_new_value;
                        left_in  = '0;
                     end
                  end
                  tpr_pkg::REQ_SAMPLE: begin
                     res_in = goal_ff;
                     if (left_ff != '0) left_in = left_dec;
                     rem_in   = {1'b0, total_ff - left_ff};
                     quo_in   = '0;
                     cnt_in   = '0;
                     phase_in = 1'b0;
                  end
                  tpr_pkg::REQ_SKIP: begin
                     left_in = (req_skip_count >= left_ff) ? '0 : left_ff - req_skip_count;
                  end
                  default: ;
               endcase
            end
         end
         tpr_pkg::ST_DIVX: begin
            rem_in = div_rem;
            quo_in = {quo_ff[31:0], div_ge};
            x_in   = {quo_ff[14:0], div_ge};
            cnt_in = cnt_ff + 6'd1;
         end
         tpr_pkg::ST_POW: begin
            pow_in = (u_val == '0) ? 17'd0 : tpr_pkg::ONE_Q16;
            m_in   = {u_val[15:0], 15'b0};
            n_in   = 4'd15;
         end
         tpr_pkg::ST_NORM: begin
            cnt_in  = '0;
            frac_in = '0;
            if (!m_ff[30]) begin
               m_in = {m_ff[29:0], 1'b0};
               n_in = n_ff - 4'd1;
            end
         end
         tpr_pkg::ST_LOG: begin
            m_in    = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
            frac_in = {frac_ff[14:0], sq_hi[31]};
            cnt_in  = cnt_ff + 6'd1;
         end
         tpr_pkg::ST_SCALE: begin
            rem_in = '0;
            cnt_in = '0;
            if (phase_ff) quo_in = {a_val, 12'b0};
            else quo_in = {8'b0, at_prod[36:12]};
         end
         tpr_pkg::ST_DIVB: begin
            rem_in = div_rem;
            quo_in = {quo_ff[31:0], div_ge};
            cnt_in = cnt_ff + 6'd1;
         end
         tpr_pkg::ST_EXPSET: begin
            v_in   = tpr_pkg::ONE_Q30;
            g_in   = 16'd0 - quo_ff[15:0];
            cnt_in = '0;
         end
         tpr_pkg::ST_EXP: begin
            if (g_ff[15]) v_in = vc_prod[60:30];
            g_in   = {g_ff[14:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
         end
         tpr_pkg::ST_EXPFIN: pow_in = exp_res;
         tpr_pkg::ST_PDONE: begin
            if (!phase_ff) begin
               p1_in    = pow_ff;
               phase_in = 1'b1;
            end
         end
         tpr_pkg::ST_BLEND1: acc_in = 34'(p1_ff) * 34'(tpr_pkg::ONE_Q16 - skew_eff);
         tpr_pkg::ST_BLEND2: begin
            acc_in = acc_ff + 34'(tpr_pkg::ONE_Q16 - pow_ff) * 34'(skew_eff) + 34'd32768;
         end
         tpr_pkg::ST_MULD: prod_in = 51'(d_val) * 51'($signed({1'b0, w_val}));
         tpr_pkg::ST_FINAL: res_in = start_ff + adj[47:16];
         tpr_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_value_in = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // outputs
   assign req_stall       = state_ff != tpr_pkg::ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_param_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpr_pkg::ST_IDLE;
         taper_ff     <= tpr_pkg::TAPER_RESET;
         skew_ff      <= '0;
         offset_ff    <= '0;
         start_ff     <= '0;
         goal_ff      <= '0;
         total_ff     <= '0;
         left_ff      <= '0;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taper_ff     <= taper_in;
         skew_ff      <= skew_in;
         offset_ff    <= offset_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         total_ff     <= total_in;
         left_ff      <= left_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      x_ff         <= x_in;
      n_ff         <= n_in;
      m_ff         <= m_in;
      frac_ff      <= frac_in;
      v_ff         <= v_in;
      g_ff         <= g_in;
      pow_ff       <= pow_in;
      p1_ff        <= p1_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule
